// File: rtl/qnq30_pkg.sv
// ----------------------------------------------------------------------------
// qnq30_pkg
// Types and constants shared by the Q30 quaternion normalizer.
// ----------------------------------------------------------------------------
package qnq30_pkg;

  localparam int unsigned FracBits  = 30;
  localparam int unsigned SqrtCells = 32;  // two radicand bits per cell
  localparam int unsigned DivCells  = 32;  // one quotient bit per cell
  localparam int unsigned Lanes     = 4;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] in_w;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_w;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } rsp_t;

  // request data that rides along the cell chains
  typedef struct packed {
    logic                   byp;
    logic                   ident;
    logic [Lanes-1:0][31:0] part;
  } side_t;

  typedef struct packed {
    logic [63:0] v;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0]            n;
    logic [Lanes-1:0][31:0] lo;
    logic [Lanes-1:0][31:0] rem;
    logic [Lanes-1:0][31:0] q;
    logic [Lanes-1:0]       ovf;
  } dv_t;

endpackage

// File: rtl/qnq30_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qnq30_sqrt_cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module qnq30_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  qnq30_pkg::side_t  side_i,
  input  qnq30_pkg::sq_t    sq_i,
  output logic              valid_o,
  output qnq30_pkg::side_t  side_o,
  output qnq30_pkg::sq_t    sq_o
);

  logic [34:0]    rem_sh;
  logic [34:0]    trial;
  logic           ge;
  qnq30_pkg::sq_t sq_d;

  always_comb begin
    rem_sh    = {sq_i.rem[32:0], sq_i.v[63:62]};
    trial     = {1'b0, sq_i.root, 2'b01};
    ge        = rem_sh >= trial;
    sq_d.v    = {sq_i.v[61:0], 2'b00};
    sq_d.rem  = ge ? rem_sh - trial : rem_sh;
    sq_d.root = {sq_i.root[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    sq_o   <= sq_d;
  end

endmodule

// File: rtl/qnq30_div_cell.sv
// ----------------------------------------------------------------------------
// qnq30_div_cell
// One restoring division step for all four parts, registered.
// ----------------------------------------------------------------------------
module qnq30_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  qnq30_pkg::side_t  side_i,
  input  qnq30_pkg::dv_t    dv_i,
  output logic              valid_o,
  output qnq30_pkg::side_t  side_o,
  output qnq30_pkg::dv_t    dv_o
);

  logic [qnq30_pkg::Lanes-1:0][32:0] r_sh;
  logic [qnq30_pkg::Lanes-1:0]       ge;
  qnq30_pkg::dv_t                    dv_d;

  always_comb begin
    dv_d.n   = dv_i.n;
    dv_d.ovf = dv_i.ovf;
    for (int l = 0; l < qnq30_pkg::Lanes; l++) begin
      r_sh[l]     = {dv_i.rem[l], dv_i.lo[l][31]};
      ge[l]       = r_sh[l] >= {1'b0, dv_i.n};
      dv_d.rem[l] = ge[l] ? 32'(r_sh[l] - {1'b0, dv_i.n}) : r_sh[l][31:0];
      dv_d.q[l]   = {dv_i.q[l][30:0], ge[l]};
      dv_d.lo[l]  = {dv_i.lo[l][30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    dv_o   <= dv_d;
  end

endmodule

// File: rtl/quaternion_normalize_q30.sv
// ----------------------------------------------------------------------------
// quaternion_normalize_q30
// Scales a Q30 quaternion to unit length through root and divider cell chains.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy is always low, every stage is a
// register in a chain of square root cells (one per root bit) and divide cells
// (one per quotient bit), so a request enters each cycle.
// The receiver cannot stall; results appear for one cycle each.
// Reset clears only the valid bits of the chain; no request is lost after it.
module quaternion_normalize_q30 #(
  parameter int unsigned FRAC_BITS = qnq30_pkg::FracBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  qnq30_pkg::req_t  req_i,
  output logic             valid_o,
  output qnq30_pkg::rsp_t  rsp_o
);

  localparam int unsigned NS = qnq30_pkg::SqrtCells;
  localparam int unsigned ND = qnq30_pkg::DivCells;
  localparam int unsigned NL = qnq30_pkg::Lanes;
  localparam logic [63:0] One2  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] Drift = 64'd1 << (2 * FRAC_BITS - 5);
  localparam logic [63:0] BandLo = One2 - Drift;
  localparam logic [63:0] BandHi = One2 + Drift;

  assign busy = 1'b0;

  // input register
  logic                 v0_q;
  logic                 op0_q;
  logic [NL-1:0][31:0]  p0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  // lane 0 carries the scalar part
  always_ff @(posedge clk_i) begin
    op0_q <= req_i.operation;
    p0_q  <= {req_i.in_z, req_i.in_y, req_i.in_x, req_i.in_w};
  end

  // squares
  logic                 v1_q, op1_q;
  logic [NL-1:0][31:0]  p1_q;
  logic [NL-1:0][63:0]  sqr1_q;

  // sum
  logic                 v2_q, op2_q;
  logic [NL-1:0][31:0]  p2_q;
  logic [63:0]          n2_q;

  // flags
  logic                 v3_q;
  qnq30_pkg::side_t     side3_q;
  logic [63:0]          n3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q <= op0_q;
    p1_q  <= p0_q;
    for (int l = 0; l < NL; l++) begin
      sqr1_q[l] <= 64'($signed(p0_q[l]) * $signed(p0_q[l]));
    end
    op2_q <= op1_q;
    p2_q  <= p1_q;
    n2_q  <= sqr1_q[0] + sqr1_q[1] + sqr1_q[2] + sqr1_q[3];
    side3_q.part  <= p2_q;
    side3_q.ident <= (n2_q == 64'd0) || n2_q[63];
    side3_q.byp   <= op2_q && !n2_q[63] && (n2_q >= BandLo) && (n2_q <= BandHi);
    n3_q <= n2_q;
  end

  // square root chain
  logic             sv [NS+1];
  qnq30_pkg::side_t ss [NS+1];
  qnq30_pkg::sq_t   sq [NS+1];

  assign sv[0]      = v3_q;
  assign ss[0]      = side3_q;
  assign sq[0].v    = n3_q;
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;

  for (genvar c = 0; c < NS; c++) begin : g_sqrt
    qnq30_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[c]),
      .side_i  (ss[c]),
      .sq_i    (sq[c]),
      .valid_o (sv[c+1]),
      .side_o  (ss[c+1]),
      .sq_o    (sq[c+1])
    );
  end

  // divider setup: dividend = |p| << FRAC_BITS
  logic                 v4_q;
  qnq30_pkg::side_t     side4_q;
  qnq30_pkg::dv_t       dv4_q;
  qnq30_pkg::dv_t       dv4_d;
  logic [NL-1:0][32:0]  mag;
  logic [NL-1:0][63:0]  dvd;

  always_comb begin
    dv4_d.n = sq[NS].root;
    for (int l = 0; l < NL; l++) begin
      mag[l] = ss[NS].part[l][31] ? 33'(-{1'b1, ss[NS].part[l]})
                                  : {1'b0, ss[NS].part[l]};
      dvd[l] = {31'd0, mag[l]} << FRAC_BITS;
      dv4_d.ovf[l] = dvd[l][63:32] >= sq[NS].root;
      dv4_d.rem[l] = dv4_d.ovf[l] ? 32'd0 : dvd[l][63:32];
      dv4_d.lo[l]  = dvd[l][31:0];
      dv4_d.q[l]   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= sv[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q <= ss[NS];
    dv4_q   <= dv4_d;
  end

  // divide chain
  logic             dvv [ND+1];
  qnq30_pkg::side_t ds  [ND+1];
  qnq30_pkg::dv_t   dd  [ND+1];

  assign dvv[0] = v4_q;
  assign ds[0]  = side4_q;
  assign dd[0]  = dv4_q;

  for (genvar c = 0; c < ND; c++) begin : g_div
    qnq30_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dvv[c]),
      .side_i  (ds[c]),
      .dv_i    (dd[c]),
      .valid_o (dvv[c+1]),
      .side_o  (ds[c+1]),
      .dv_o    (dd[c+1])
    );
  end

  // saturation and result select
  logic [NL-1:0][32:0] qf;
  logic [NL-1:0][31:0] res;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      qf[l] = {dd[ND].ovf[l], dd[ND].q[l]};
      if (ds[ND].byp) begin
        res[l] = ds[ND].part[l];
      end else if (ds[ND].ident) begin
        res[l] = (l == 0) ? 32'(64'd1 << FRAC_BITS) : 32'd0;
      end else if (ds[ND].part[l][31]) begin
        res[l] = (qf[l] > 33'h080000000) ? 32'h80000000 : 32'(-qf[l]);
      end else begin
        res[l] = (qf[l] > 33'h07FFFFFFF) ? 32'h7FFFFFFF : qf[l][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dvv[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_o <= {res[0], res[1], res[2], res[3]};
  end

endmodule

// File: sim/tb_quaternion_normalize_q30.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_normalize_q30
// Self-checking bench for the Q30 quaternion normalizer: directed rows and
// random requests are compared part by part against table values or a local normalizer.
// ----------------------------------------------------------------------------
module tb_quaternion_normalize_q30;

  localparam int unsigned NumRandom = 1630;
  localparam int unsigned DrainCycles = 120;

  typedef enum logic {
    OpAlways = 1'b0,
    OpBand   = 1'b1
  } op_e;

  typedef struct {
    qnq30_pkg::req_t req;
    logic known;
    qnq30_pkg::rsp_t rsp;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  qnq30_pkg::req_t req_i;
  logic valid_o;
  qnq30_pkg::rsp_t rsp_o;

  qnq30_pkg::rsp_t unit_q[$];
  int   mismatches;
  row_t rows[$];

  quaternion_normalize_q30 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] scale_lane(logic signed [31:0] p, logic [63:0] n);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (p < 0) ? 64'(-64'(p)) : 64'(p);
    quo = (mag << qnq30_pkg::FracBits) / n;
    if (p < 0) begin
      if (quo > 64'h8000_0000) quo = 64'h8000_0000;
      return 32'(-quo);
    end
    if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  function automatic qnq30_pkg::rsp_t normalize(qnq30_pkg::req_t r);
    logic signed [63:0] sq;
    logic [63:0] lo_band;
    logic [63:0] hi_band;
    logic [63:0] n;
    qnq30_pkg::rsp_t o;
    sq = 64'(r.in_w) * 64'(r.in_w) + 64'(r.in_x) * 64'(r.in_x)
       + 64'(r.in_y) * 64'(r.in_y) + 64'(r.in_z) * 64'(r.in_z);
    lo_band = (64'd1 << (2 * qnq30_pkg::FracBits)) - (64'd1 << (2 * qnq30_pkg::FracBits - 5));
    hi_band = (64'd1 << (2 * qnq30_pkg::FracBits)) + (64'd1 << (2 * qnq30_pkg::FracBits - 5));
    if (r.operation == OpBand && sq >= 0 && 64'(sq) >= lo_band && 64'(sq) <= hi_band) begin
      o.out_w = r.in_w;
      o.out_x = r.in_x;
      o.out_y = r.in_y;
      o.out_z = r.in_z;
      return o;
    end
    if (sq <= 0) begin
      o.out_w = 32'sd1 <<< qnq30_pkg::FracBits;
      o.out_x = '0;
      o.out_y = '0;
      o.out_z = '0;
      return o;
    end
    n = floor_root(64'(sq));
    o.out_w = scale_lane(r.in_w, n);
    o.out_x = scale_lane(r.in_x, n);
    o.out_y = scale_lane(r.in_y, n);
    o.out_z = scale_lane(r.in_z, n);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // results are checked at the rising edge
  always @(posedge clk_i) begin
    qnq30_pkg::rsp_t want;
    if (rst_ni && valid_o) begin
      if (unit_q.size() == 0) begin
        report_mismatch("unexpected result", rsp_o.out_w, 32'd0);
      end else begin
        want = unit_q.pop_front();
        if (rsp_o.out_w !== want.out_w) report_mismatch("out_w", rsp_o.out_w, want.out_w);
        if (rsp_o.out_x !== want.out_x) report_mismatch("out_x", rsp_o.out_x, want.out_x);
        if (rsp_o.out_y !== want.out_y) report_mismatch("out_y", rsp_o.out_y, want.out_y);
        if (rsp_o.out_z !== want.out_z) report_mismatch("out_z", rsp_o.out_z, want.out_z);
      end
    end
  end

  function automatic qnq30_pkg::req_t mk(logic op, logic [31:0] w, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z);
    qnq30_pkg::req_t r;
    r.operation = op;
    r.in_w = w;
    r.in_x = x;
    r.in_y = y;
    r.in_z = z;
    return r;
  endfunction

  function automatic qnq30_pkg::rsp_t mkr(logic [31:0] w, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
    qnq30_pkg::rsp_t o;
    o.out_w = w;
    o.out_x = x;
    o.out_y = y;
    o.out_z = z;
    return o;
  endfunction

  task automatic add_row(qnq30_pkg::req_t r, logic known, qnq30_pkg::rsp_t o);
    row_t e;
    e.req = r;
    e.known = known;
    e.rsp = o;
    rows.push_back(e);
  endtask

  // drives one request and holds it until accepted
  task automatic send(qnq30_pkg::req_t r, qnq30_pkg::rsp_t want);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    unit_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic idle_burst(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rnd_part(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h8000_0000)) >>> $urandom_range(0, 8));
      default: return 32'($urandom_range(0, 2048)) - 32'd1024;
    endcase
  endfunction

  function automatic qnq30_pkg::req_t rnd_req();
    int mode;
    logic [31:0] one;
    mode = $urandom_range(0, 9);
    one = 32'd1 << qnq30_pkg::FracBits;
    if (mode < 3) begin
      // near the unit sphere, to exercise the band
      return mk(1'($urandom_range(0, 1)),
                one + 32'($urandom_range(0, 1 << 26)) - (32'd1 << 25),
                32'($urandom_range(0, 1 << 25)) - (32'd1 << 24),
                32'($urandom_range(0, 1 << 25)) - (32'd1 << 24),
                32'($urandom_range(0, 1 << 25)) - (32'd1 << 24));
    end
    if (mode == 3) return mk(1'($urandom_range(0, 1)), rnd_part(2), rnd_part(2),
                             rnd_part(2), rnd_part(2));
    if (mode < 6) return mk(1'($urandom_range(0, 1)), rnd_part(1), rnd_part(1),
                            rnd_part(1), rnd_part(1));
    return mk(1'($urandom_range(0, 1)), rnd_part(0), rnd_part(0), rnd_part(0), rnd_part(0));
  endfunction

  initial begin
    qnq30_pkg::req_t r;
    qnq30_pkg::rsp_t ident;
    logic [31:0] one;
    int tail;
    one = 32'd1 << qnq30_pkg::FracBits;
    ident = mkr(one, 0, 0, 0);
    mismatches = 0;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: zero norm, exact units, band edges, overflow, saturation
    add_row(mk(OpAlways, 0, 0, 0, 0), 1, ident);
    add_row(mk(OpBand, 0, 0, 0, 0), 1, ident);
    add_row(mk(OpAlways, one, 0, 0, 0), 1, mkr(one, 0, 0, 0));
    add_row(mk(OpAlways, 0, one, 0, 0), 1, mkr(0, one, 0, 0));
    add_row(mk(OpAlways, 0, 0, -one, 0), 1, mkr(0, 0, -one, 0));
    add_row(mk(OpBand, one + 5, 3, -7, 1), 1, mkr(one + 5, 3, -7, 1));
    add_row(mk(OpAlways, one + 5, 3, -7, 1), 0, ident);
    // all parts at min: sum wraps to zero
    add_row(mk(OpAlways, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
            1, ident);
    // two at min: sum is 2^63, negative
    add_row(mk(OpBand, 32'h8000_0000, 32'h8000_0000, 0, 0), 1, ident);
    add_row(mk(OpAlways, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
            0, ident);
    add_row(mk(OpAlways, 32'h7FFF_FFFF, 0, 0, 0), 0, ident);
    add_row(mk(OpAlways, 32'h8000_0000, 0, 0, 0), 0, ident);
    // a single nonzero part always scales to exactly one in magnitude, sign kept
    add_row(mk(OpAlways, 1, 0, 0, 0), 1, mkr(one, 0, 0, 0));
    add_row(mk(OpAlways, -1, 0, 0, 0), 1, mkr(-one, 0, 0, 0));
    add_row(mk(OpAlways, 1, 1, 1, 1), 0, ident);
    add_row(mk(OpBand, 32'h4000_0000 + 32'h0100_0000, 0, 0, 0), 0, ident);
    add_row(mk(OpBand, 32'h3F00_0000, 0, 0, 0), 0, ident);
    add_row(mk(OpBand, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000), 0, ident);
    add_row(mk(OpBand, -1, -1, -1, -1), 0, ident);
    add_row(mk(OpAlways, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 0, ident);
    add_row(mk(OpAlways, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 0, ident);
    add_row(mk(OpBand, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1), 0, ident);

    foreach (rows[i]) begin
      send(rows[i].req, rows[i].known ? rows[i].rsp : normalize(rows[i].req));
      idle_burst(1);
    end

    // hold off until the pipeline is empty
    start <= 1'b0;
    while (unit_q.size() != 0) @(negedge clk_i);

    tail = NumRandom - NumRandom / 5;
    for (int i = 0; i < NumRandom; i++) begin
      r = rnd_req();
      send(r, normalize(r));
      idle_burst(i < tail);
    end
    start <= 1'b0;

    while (unit_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("quaternion_normalize_q30 verification clean");
    end else begin
      $display("quaternion_normalize_q30 verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("quaternion_normalize_q30 verification failed");
    $finish;
  end

endmodule

// File: quaternion_normalize_q30.f
rtl/qnq30_pkg.sv
rtl/qnq30_sqrt_cell.sv
rtl/qnq30_div_cell.sv
rtl/quaternion_normalize_q30.sv
sim/tb_quaternion_normalize_q30.sv
